@@ sv/multi_reader_sample_ring_buffer_defines.svh @@
// Assertion helpers for the multi-reader sample ring buffer.
`ifndef MULTI_READER_SAMPLE_RING_BUFFER_DEFINES_SVH
`define MULTI_READER_SAMPLE_RING_BUFFER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold whenever the block is out of reset.
`define MRSRB_ASSERT(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define MRSRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRSRB_ASSERT(lbl, clk, rst_n, cond, msg)
`define MRSRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ sv/mrsrb_pkg.sv @@
package mrsrb_pkg;

    // Default sizes.
    localparam int DEF_DEPTH       = 1024;
    localparam int DEF_READERS     = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    // Fixed field widths.
    localparam int CMD_W    = 3;
    localparam int READER_W = 3;
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 10;
    localparam int STATUS_W = 2;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Command codes.
    localparam t_cmd CMD_WRITE     = 3'd0;
    localparam t_cmd CMD_READ      = 3'd1;
    localparam t_cmd CMD_CREATE    = 3'd2;
    localparam t_cmd CMD_REMOVE    = 3'd3;
    localparam t_cmd CMD_FLUSH     = 3'd4;
    localparam t_cmd CMD_FLUSH_ALL = 3'd5;
    localparam t_cmd CMD_DISCARD   = 3'd6;
    localparam t_cmd CMD_LENGTH    = 3'd7;

    // Status codes.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_INACTIVE = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_OVERRUN  = 2'd3;

    // Largest amount that fits the result field.
    localparam logic [COUNT_W-1:0] AMOUNT_MAX = '1;

endpackage

@@ sv/mrsrb_cmd_if.sv @@
interface mrsrb_cmd_if
    import mrsrb_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [CMD_W-1:0]            command;
    logic [READER_W-1:0]         reader;
    logic signed [SAMPLE_W-1:0]  write_sample;
    logic [COUNT_W-1:0]          count;

    modport source (output valid, command, reader, write_sample, count, input ready);
    modport sink   (input valid, command, reader, write_sample, count, output ready);
endinterface

@@ sv/mrsrb_res_if.sv @@
interface mrsrb_res_if
    import mrsrb_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic signed [SAMPLE_W-1:0]  read_sample;
    logic [COUNT_W-1:0]          amount;
    logic [STATUS_W-1:0]         status;

    modport source (output valid, read_sample, amount, status, input ready);
    modport sink   (input valid, read_sample, amount, status, output ready);
endinterface

@@ sv/multi_reader_sample_ring_buffer.sv @@
// Multi-reader sample ring buffer with overwrite of the oldest sample.
// Commands arrive on i_cmd (valid/ready); each accepted beat gives exactly
// one result beat on o_res (valid/ready), in command order.
// Commands: write, read, create, remove, flush one, flush all, discard and
// length query. A write that would overrun an active reader drops that
// reader's oldest sample and reports status overrun.
// The sample memory read is registered at the edge that accepts the command beat.
// Throughput: one command per cycle while o_res is taken, set by the single
// port of the sample memory and the combinational per-reader compares.
// Results pass through a holding stage and an output register, so a new
// command is still accepted while a finished result waits on o_res.
// When o_res stalls, the output register holds its beat, the holding stage
// fills, and i_cmd.ready drops until o_res is taken again.
// Reset (synchronous, active low) clears the write position, all read
// positions and all active bits and empties the result stages. The sample
// memory is not cleared; readers only ever reach samples written after they
// were created or flushed.
module multi_reader_sample_ring_buffer
    import mrsrb_pkg::*;
#(
    parameter int DEPTH       = DEF_DEPTH,
    parameter int READERS     = DEF_READERS,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mrsrb_cmd_if.sink   i_cmd,
    mrsrb_res_if.source o_res
);

`include "multi_reader_sample_ring_buffer_defines.svh"

    localparam int AW = $clog2(DEPTH);
    localparam int RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int CW = (AW > COUNT_W) ? AW : COUNT_W;

    // Position increment with wrap at the store depth.
    function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] p);
        inc_wrap = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    // Sample memory.
    logic [SAMPLE_BITS-1:0] mem [DEPTH];
    logic [SAMPLE_BITS-1:0] r_mem_q;

    // Positions and reader state.
    logic [AW-1:0]  r_wpos, n_wpos;
    logic [AW-1:0]  r_rpos [READERS];
    logic [AW-1:0]  n_rpos [READERS];
    logic           r_act  [READERS];
    logic           n_act  [READERS];

    // Holding stage and output register.
    logic                  r_pend_valid;
    logic                  r_pend_mem;
    logic [COUNT_W-1:0]    r_pend_amount;
    t_status               r_pend_status;
    logic                  r_out_valid;
    logic [SAMPLE_W-1:0]   r_out_sample;
    logic [COUNT_W-1:0]    r_out_amount;
    t_status               r_out_status;

    logic                  pend_move;
    logic                  acc;
    logic [RW-1:0]         sel;
    logic                  sel_ok;
    logic                  active;
    logic [AW-1:0]         cur;
    logic [AW:0]           diff;
    logic [AW-1:0]         len;
    logic [CW-1:0]         len_c;
    logic [CW-1:0]         cnt_c;
    logic [CW-1:0]         disc_c;
    logic [CW:0]           disc_sum;
    logic [AW-1:0]         disc_pos;
    logic [AW-1:0]         w_next;
    logic                  rd_ok;
    logic                  overrun;
    logic [COUNT_W-1:0]    n_amount;
    t_status               n_status;
    logic [31:0]           wr_ext;
    logic [31:0]           rd_ext;

    // Handshake: take a command whenever the holding stage is free or moving on.
    assign pend_move   = r_pend_valid && (!r_out_valid || o_res.ready);
    assign i_cmd.ready = !r_pend_valid || pend_move;
    assign acc         = i_cmd.valid && i_cmd.ready;

    // Addressed reader and its unread length.
    assign sel    = RW'(i_cmd.reader);
    assign sel_ok = 32'(i_cmd.reader) < READERS;
    assign active = sel_ok && r_act[sel];
    assign cur    = r_rpos[sel];
    assign diff   = {1'b0, r_wpos} - {1'b0, cur};
    assign len    = diff[AW] ? AW'(diff + (AW+1)'(DEPTH)) : diff[AW-1:0];
    assign len_c  = CW'(len);
    assign w_next = inc_wrap(r_wpos);

    // Discard is clamped to the unread length, then wraps the position.
    assign cnt_c    = CW'(i_cmd.count);
    assign disc_c   = (cnt_c < len_c) ? cnt_c : len_c;
    assign disc_sum = (CW+1)'(cur) + (CW+1)'(disc_c);
    assign disc_pos = (disc_sum >= (CW+1)'(DEPTH)) ? AW'(disc_sum - (CW+1)'(DEPTH))
                                                   : AW'(disc_sum);

    assign rd_ok = (i_cmd.command == CMD_READ) && active && (len != '0);

    // Sample width conversion on the way in and out.
    assign wr_ext = 32'(i_cmd.write_sample);
    assign rd_ext = 32'(signed'(r_mem_q));

    // Next state of every reader lane.
    always_comb begin
        overrun = 1'b0;
        for (int i = 0; i < READERS; i++) begin
            n_rpos[i] = r_rpos[i];
            n_act[i]  = r_act[i];
            case (i_cmd.command)
                CMD_WRITE: begin
                    if (r_act[i] && (r_rpos[i] == w_next)) begin
                        n_rpos[i] = inc_wrap(r_rpos[i]);
                        overrun   = 1'b1;
                    end
                end
                CMD_FLUSH_ALL: begin
                    if (r_act[i]) begin
                        n_rpos[i] = r_wpos;
                    end
                end
                default: begin
                    if (sel_ok && (RW'(i) == sel)) begin
                        case (i_cmd.command)
                            CMD_READ: begin
                                if (rd_ok) begin
                                    n_rpos[i] = inc_wrap(r_rpos[i]);
                                end
                            end
                            CMD_CREATE: begin
                                if (!r_act[i]) begin
                                    n_act[i]  = 1'b1;
                                    n_rpos[i] = r_wpos;
                                end
                            end
                            CMD_REMOVE: begin
                                n_act[i] = 1'b0;
                            end
                            CMD_FLUSH: begin
                                if (r_act[i]) begin
                                    n_rpos[i] = r_wpos;
                                end
                            end
                            CMD_DISCARD: begin
                                if (r_act[i]) begin
                                    n_rpos[i] = disc_pos;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            endcase
        end
    end

    // Result fields of the accepted command.
    always_comb begin
        n_wpos   = r_wpos;
        n_amount = '0;
        n_status = ST_OK;
        case (i_cmd.command)
            CMD_WRITE: begin
                n_wpos   = w_next;
                n_status = overrun ? ST_OVERRUN : ST_OK;
            end
            CMD_READ: begin
                if (!active) begin
                    n_status = ST_INACTIVE;
                end else if (len == '0) begin
                    n_status = ST_EMPTY;
                end
            end
            CMD_CREATE: begin
                n_status = sel_ok ? ST_OK : ST_INACTIVE;
            end
            CMD_FLUSH_ALL: begin
                n_status = ST_OK;
            end
            CMD_DISCARD: begin
                if (!active) begin
                    n_status = ST_INACTIVE;
                end else begin
                    n_amount = disc_c[COUNT_W-1:0];
                end
            end
            CMD_LENGTH: begin
                if (!active) begin
                    n_status = ST_INACTIVE;
                end else if (len_c > CW'(AMOUNT_MAX)) begin
                    n_amount = AMOUNT_MAX;
                end else begin
                    n_amount = len_c[COUNT_W-1:0];
                end
            end
            default: begin
                n_status = active ? ST_OK : ST_INACTIVE;
            end
        endcase
    end

    // Sample memory: write on a write beat, registered read on a good read.
    always_ff @(posedge i_clk) begin
        if (acc && (i_cmd.command == CMD_WRITE)) begin
            mem[r_wpos] <= wr_ext[SAMPLE_BITS-1:0];
        end
        if (acc && rd_ok) begin
            r_mem_q <= mem[cur];
        end
    end

    // Position and reader state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            for (int i = 0; i < READERS; i++) begin
                r_rpos[i] <= '0;
                r_act[i]  <= 1'b0;
            end
        end else if (acc) begin
            r_wpos <= n_wpos;
            for (int i = 0; i < READERS; i++) begin
                r_rpos[i] <= n_rpos[i];
                r_act[i]  <= n_act[i];
            end
        end
    end

    // Holding stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (acc) begin
            r_pend_valid <= 1'b1;
        end else if (pend_move) begin
            r_pend_valid <= 1'b0;
        end
        if (acc) begin
            r_pend_mem    <= rd_ok;
            r_pend_amount <= n_amount;
            r_pend_status <= n_status;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pend_move) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (pend_move) begin
            r_out_sample <= r_pend_mem ? rd_ext[SAMPLE_W-1:0] : '0;
            r_out_amount <= r_pend_amount;
            r_out_status <= r_pend_status;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.read_sample = signed'(r_out_sample);
    assign o_res.amount      = r_out_amount;
    assign o_res.status      = r_out_status;

    // A good read leaves the holding stage waiting on memory data.
    `MRSRB_ASSERT_NEXT(a_read_pend, i_clk, i_rst_n, acc && rd_ok, r_pend_valid && r_pend_mem,
        "read beat did not reach the holding stage")

    // A write beat moves the write position on by one, with wrap.
    `MRSRB_ASSERT_NEXT(a_wpos_step, i_clk, i_rst_n, acc && (i_cmd.command == CMD_WRITE),
        r_wpos == $past(w_next), "write position did not advance by one")

    // Only a successful read carries a sample.
    `MRSRB_ASSERT(a_sample_zero, i_clk, i_rst_n,
        !r_out_valid || (r_out_status == ST_OK) || (r_out_sample == '0),
        "sample present on a failed command")

endmodule

@@ sim/tb_multi_reader_sample_ring_buffer.sv @@
`timescale 1ns / 100ps

module tb_multi_reader_sample_ring_buffer;
    import mrsrb_pkg::*;

    localparam int DEPTH        = DEF_DEPTH;
    localparam int READERS      = DEF_READERS;
    localparam int SAMPLE_BITS  = DEF_SAMPLE_BITS;
    localparam int RANDOM_ITEMS = 620;

    typedef struct packed {
        t_cmd                       command;
        logic [READER_W-1:0]        reader;
        logic signed [SAMPLE_W-1:0] write_sample;
        logic [COUNT_W-1:0]         count;
    } t_ring_cmd;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] read_sample;
        logic [COUNT_W-1:0]         amount;
        t_status                    status;
    } t_ring_res;

    logic i_clk;
    logic i_rst_n;

    mrsrb_cmd_if cmd_bus ();
    mrsrb_res_if res_bus ();

    multi_reader_sample_ring_buffer #(
        .DEPTH      (DEPTH),
        .READERS    (READERS),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_bus),
        .o_res  (res_bus)
    );

    // Predicted ring state.
    logic signed [SAMPLE_W-1:0] ring_store [DEPTH];
    int unsigned                ring_wr;
    int unsigned                ring_rd [READERS];
    bit                         ring_live [READERS];

    // Stimulus and checking bookkeeping.
    t_ring_cmd pending_cmds [$];
    t_ring_res awaited_results [$];
    bit        gen_live [READERS];
    int        cmds_queued;
    int        cmds_accepted;
    int        results_checked;
    int        overrun_hits;
    int        empty_hits;
    int        inactive_hits;
    int        fail_count;

    // Handshake flags and idle pattern state.
    logic cmd_taken;
    logic res_taken;
    int   cmd_gap;
    int   res_stall;
    bit   cmd_calm;
    bit   res_calm;

    function automatic int unsigned unread_of(int idx);
        return (ring_wr + DEPTH - ring_rd[idx]) % DEPTH;
    endfunction

    // Applies one command to the predicted ring and returns its result beat.
    function automatic t_ring_res ring_predict(t_ring_cmd c);
        t_ring_res   r;
        int          idx;
        bit          ok;
        int unsigned len;
        r = '0;
        r.status = ST_OK;
        idx = c.reader;
        ok = (idx < READERS) && ring_live[idx];
        case (c.command)
            CMD_WRITE: begin
                ring_store[ring_wr] = c.write_sample;
                for (int i = 0; i < READERS; i++) begin
                    if (ring_live[i] && unread_of(i) == DEPTH - 1) begin
                        ring_rd[i] = (ring_rd[i] + 1) % DEPTH;
                        r.status = ST_OVERRUN;
                    end
                end
                ring_wr = (ring_wr + 1) % DEPTH;
            end
            CMD_READ: begin
                if (!ok) begin
                    r.status = ST_INACTIVE;
                end else if (unread_of(idx) == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_sample = ring_store[ring_rd[idx]];
                    ring_rd[idx] = (ring_rd[idx] + 1) % DEPTH;
                end
            end
            CMD_CREATE: begin
                if (idx >= READERS) begin
                    r.status = ST_INACTIVE;
                end else if (!ring_live[idx]) begin
                    ring_live[idx] = 1'b1;
                    ring_rd[idx] = ring_wr;
                end
            end
            CMD_REMOVE: begin
                if (!ok) r.status = ST_INACTIVE;
                else ring_live[idx] = 1'b0;
            end
            CMD_FLUSH: begin
                if (!ok) r.status = ST_INACTIVE;
                else ring_rd[idx] = ring_wr;
            end
            CMD_FLUSH_ALL: begin
                for (int i = 0; i < READERS; i++) begin
                    if (ring_live[i]) ring_rd[i] = ring_wr;
                end
            end
            CMD_DISCARD: begin
                if (!ok) begin
                    r.status = ST_INACTIVE;
                end else begin
                    len = unread_of(idx);
                    len = (c.count < len) ? c.count : len;
                    r.amount = len[COUNT_W-1:0];
                    ring_rd[idx] = (ring_rd[idx] + len) % DEPTH;
                end
            end
            CMD_LENGTH: begin
                if (!ok) begin
                    r.status = ST_INACTIVE;
                end else begin
                    len = unread_of(idx);
                    r.amount = (len > AMOUNT_MAX) ? AMOUNT_MAX : len[COUNT_W-1:0];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Queues one command and tracks which readers it leaves active.
    task automatic push_cmd(t_cmd command, int reader, int sample, int count);
        t_ring_cmd c;
        c.command      = command;
        c.reader       = reader[READER_W-1:0];
        c.write_sample = sample[SAMPLE_W-1:0];
        c.count        = count[COUNT_W-1:0];
        pending_cmds.push_back(c);
        cmds_queued++;
        if (command == CMD_CREATE) gen_live[c.reader] = 1'b1;
        if (command == CMD_REMOVE) gen_live[c.reader] = 1'b0;
    endtask

    // Picks an active reader when asked and one exists, else any reader.
    function automatic int pick_reader(bit want_live);
        int live_list [$];
        for (int i = 0; i < READERS; i++) begin
            if (gen_live[i]) live_list.push_back(i);
        end
        if (want_live && live_list.size() > 0) begin
            return live_list[$urandom_range(0, live_list.size() - 1)];
        end
        return $urandom_range(0, READERS - 1);
    endfunction

    function automatic void flag_mismatch(string field, int want, int got);
        fail_count++;
        $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Command driver: presents queued beats with random gaps between them.
    always @(negedge i_clk) begin
        t_ring_cmd nxt;
        if (!i_rst_n) begin
            cmd_bus.valid <= 1'b0;
        end else if (!cmd_bus.valid || cmd_taken) begin
            if (cmd_gap > 0) begin
                cmd_bus.valid <= 1'b0;
                cmd_gap--;
            end else if (pending_cmds.size() > 0) begin
                nxt = pending_cmds.pop_front();
                cmd_bus.command      <= nxt.command;
                cmd_bus.reader       <= nxt.reader;
                cmd_bus.write_sample <= nxt.write_sample;
                cmd_bus.count        <= nxt.count;
                cmd_bus.valid        <= 1'b1;
                if ($urandom_range(0, 39) == 0) cmd_calm = !cmd_calm;
                cmd_gap = cmd_calm ? 0 : $urandom_range(0, 3);
            end else begin
                cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Result sink: stalls a random number of cycles after each beat.
    always @(negedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
        end else begin
            if (res_taken) begin
                if ($urandom_range(0, 39) == 0) res_calm = !res_calm;
                n = res_calm ? 0 : $urandom_range(0, 3);
            end else begin
                n = res_stall;
            end
            if (n > 0) begin
                res_bus.ready <= 1'b0;
                res_stall = n - 1;
            end else begin
                res_bus.ready <= 1'b1;
                res_stall = 0;
            end
        end
    end

    // Monitor: predicts on each command beat and checks each result beat.
    always @(posedge i_clk) begin
        t_ring_cmd c;
        t_ring_res want;
        cmd_taken <= i_rst_n && cmd_bus.valid && cmd_bus.ready;
        res_taken <= i_rst_n && res_bus.valid && res_bus.ready;
        if (i_rst_n && cmd_bus.valid && cmd_bus.ready) begin
            c.command      = cmd_bus.command;
            c.reader       = cmd_bus.reader;
            c.write_sample = cmd_bus.write_sample;
            c.count        = cmd_bus.count;
            awaited_results.push_back(ring_predict(c));
            cmds_accepted++;
        end
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (awaited_results.size() == 0) begin
                fail_count++;
                $error("result beat with no command waiting for it");
            end else begin
                want = awaited_results.pop_front();
                results_checked++;
                if (res_bus.read_sample !== want.read_sample) begin
                    flag_mismatch("read_sample", want.read_sample, res_bus.read_sample);
                end
                if (res_bus.amount !== want.amount) begin
                    flag_mismatch("amount", want.amount, res_bus.amount);
                end
                if (res_bus.status !== want.status) begin
                    flag_mismatch("status", want.status, res_bus.status);
                end
                if (want.status == ST_OVERRUN) overrun_hits++;
                if (want.status == ST_EMPTY) empty_hits++;
                if (want.status == ST_INACTIVE) inactive_hits++;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int directed_cmds;
        int kind;
        int rdr;
        int n;

        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_WRITE;
        cmd_bus.reader       = '0;
        cmd_bus.write_sample = '0;
        cmd_bus.count        = '0;
        res_bus.ready        = 1'b0;
        i_rst_n              = 1'b0;
        cmd_taken            = 1'b0;
        res_taken            = 1'b0;
        cmd_gap              = 0;
        res_stall            = 0;
        ring_wr              = 0;
        for (int i = 0; i < READERS; i++) begin
            ring_rd[i]   = 0;
            ring_live[i] = 1'b0;
            gen_live[i]  = 1'b0;
        end

        // Directed: every command but write on inactive readers, empty reads,
        // sample extremes, clamped and zero discards, flushes and removal.
        push_cmd(CMD_READ, 0, 0, 0);
        push_cmd(CMD_LENGTH, 5, 0, 0);
        push_cmd(CMD_DISCARD, 2, 0, 1023);
        push_cmd(CMD_REMOVE, 1, 0, 0);
        push_cmd(CMD_FLUSH, 3, 0, 0);
        push_cmd(CMD_FLUSH_ALL, 0, 0, 0);
        push_cmd(CMD_CREATE, 0, 0, 0);
        push_cmd(CMD_CREATE, 0, 0, 0);
        push_cmd(CMD_READ, 0, 0, 0);
        push_cmd(CMD_LENGTH, 0, 0, 0);
        push_cmd(CMD_WRITE, 0, 32767, 0);
        push_cmd(CMD_WRITE, 0, -32768, 0);
        push_cmd(CMD_WRITE, 0, 0, 0);
        push_cmd(CMD_WRITE, 0, -1, 0);
        push_cmd(CMD_CREATE, 7, 0, 0);
        push_cmd(CMD_READ, 0, 0, 0);
        push_cmd(CMD_LENGTH, 0, 0, 0);
        push_cmd(CMD_DISCARD, 0, 0, 0);
        push_cmd(CMD_READ, 0, 0, 0);
        push_cmd(CMD_DISCARD, 0, 0, 1023);
        push_cmd(CMD_WRITE, 7, 16'h5A5A, 1023);
        push_cmd(CMD_FLUSH, 0, 0, 0);
        push_cmd(CMD_FLUSH_ALL, 0, 0, 0);
        push_cmd(CMD_REMOVE, 7, 0, 0);
        push_cmd(CMD_LENGTH, 7, -1, 1023);
        directed_cmds = cmds_queued;

        // Random: well-formed create/write/read runs, other commands on picked
        // readers and some fully random noise.
        while (cmds_queued - directed_cmds < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 10) begin
                push_cmd(t_cmd'($urandom_range(0, 7)), $urandom, $urandom, $urandom);
            end else if (kind < 35) begin
                repeat ($urandom_range(1, 12)) begin
                    push_cmd(CMD_WRITE, $urandom, $urandom, $urandom);
                end
            end else if (kind < 55) begin
                rdr = pick_reader(1'b1);
                if (!gen_live[rdr]) push_cmd(CMD_CREATE, rdr, 0, 0);
                repeat ($urandom_range(1, 10)) push_cmd(CMD_READ, rdr, 0, 0);
            end else if (kind < 62) begin
                push_cmd(CMD_CREATE, pick_reader(1'b0), $urandom, $urandom);
            end else if (kind < 67) begin
                push_cmd(CMD_REMOVE, pick_reader($urandom_range(0, 3) != 0), 0, 0);
            end else if (kind < 72) begin
                push_cmd(CMD_FLUSH, pick_reader($urandom_range(0, 3) != 0), 0, 0);
            end else if (kind < 75) begin
                push_cmd(CMD_FLUSH_ALL, $urandom, $urandom, $urandom);
            end else if (kind < 85) begin
                n = $urandom_range(0, 1) ? $urandom_range(0, 8) : $urandom_range(0, 1023);
                push_cmd(CMD_DISCARD, pick_reader(1'b1), $urandom, n);
            end else if (kind < 95) begin
                push_cmd(CMD_LENGTH, pick_reader(1'b1), $urandom, $urandom);
            end else begin
                push_cmd(CMD_READ, pick_reader(1'b0), $urandom, $urandom);
            end
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_cmds.size() > 0 || cmd_bus.valid || awaited_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Ran %0d commands (%0d directed) and checked %0d results.",
                 cmds_accepted, directed_cmds, results_checked);
        $display("Seen: %0d overrun writes, %0d empty reads, %0d inactive-reader answers.",
                 overrun_hits, empty_hits, inactive_hits);
        if (fail_count == 0) begin
            $display("** multi_reader_sample_ring_buffer: PASSED **");
        end else begin
            $display("** multi_reader_sample_ring_buffer: FAILED **");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #6_000_000;
        $display("Timeout: %0d results still outstanding.", awaited_results.size());
        $display("** multi_reader_sample_ring_buffer: FAILED **");
        $finish;
    end

endmodule

@@ multi_reader_sample_ring_buffer.f @@
+incdir+sv
sv/mrsrb_pkg.sv
sv/mrsrb_cmd_if.sv
sv/mrsrb_res_if.sv
sv/multi_reader_sample_ring_buffer.sv
sim/tb_multi_reader_sample_ring_buffer.sv
